@@ hw/rtl/mlpq_pkg.sv @@
// Shared constants, codes and control/status types of the multilevel priority task queue.
package mlpq_pkg;

    localparam int DEF_LEVELS      = 8;
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_HANDLE_BITS = 16;

    localparam int OPCODE_W   = 2;
    localparam int PRIO_W     = 8;
    localparam int MAXLVL_W   = 3;
    localparam int STATUS_W   = 2;
    localparam int PENDING_W  = 7;
    localparam int CURTOP_W   = 3;

    localparam logic [MAXLVL_W-1:0] MAX_LEVEL_RESET = 3'd7;

    localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_PUSH_WR = 6'b000010,
        S_POP_RD  = 6'b000100,
        S_POP_WR  = 6'b001000,
        S_FALL    = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    typedef struct packed {
        logic accept;
        logic push_wr;
        logic pop_rd;
        logic pop_wr;
        logic fall_step;
        logic out_load;
    } mlpq_cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                pool_full;
        logic                top_empty;
        logic                pop_last;
        logic                fall_done;
    } mlpq_stat_t;

endpackage

@@ hw/rtl/multilevel_priority_task_queue_top.sv @@
// One operation at a time: a new one is accepted only in the idle state, once the result of
// the previous one has been loaded. Clear, refused and no-op operations go straight to the
// result; a push reads the level tail, then writes; a pop reads, then writes, and when its
// level empties walks down to the next nonempty level or level 0. A result not taken stalls.
// Reset (aresetn low, synchronous): all levels empty, free list back to entry 0,
// count and top level zero, max_level 7, no result pending. No memory clearing pass.
module multilevel_priority_task_queue_top
    import mlpq_pkg::*;
#(
    parameter int LEVELS      = DEF_LEVELS,
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS,
    localparam int IN_W  = ((PRIO_W + HANDLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((HANDLE_BITS + PENDING_W + CURTOP_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MAXLVL_W-1:0] cfg_data,    // max_level
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,     // priority_req, task_handle, zero pad
    input  logic [OPCODE_W-1:0] s_tuser,     // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,     // popped_handle, pending_count, current_top, pad
    output logic [STATUS_W-1:0] m_tuser      // status
);

    mlpq_cmd_t  cmd;
    mlpq_stat_t stat;

    assign cfg_ready = 1'b1;

    mlpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlpq_datapath #(
        .LEVELS      (LEVELS),
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ hw/rtl/mlpq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
module mlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mlpq_ctrl.sv @@
// Operation sequencer of the task queue: steps each operation and owns the result valid.
module mlpq_ctrl
    import mlpq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  mlpq_stat_t stat,
    output mlpq_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    case (stat.op)
                        OP_PUSH: state_next = stat.pool_full ? S_DONE : S_PUSH_WR;
                        OP_POP:  state_next = stat.top_empty ? S_DONE : S_POP_RD;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_PUSH_WR: begin
                cmd.push_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_WR;
            end
            S_POP_WR: begin
                cmd.pop_wr = 1'b1;
                state_next = stat.pop_last ? S_FALL : S_DONE;
            end
            S_FALL: begin
                // walk down one level a cycle to the next nonempty one, or to level 0
                cmd.fall_step = 1'b1;
                if (stat.fall_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

@@ hw/rtl/mlpq_datapath.sv @@
// Queue datapath: level head/tail, link and payload memories, free list, counters, result register.
module mlpq_datapath
    import mlpq_pkg::*;
#(
    parameter int LEVELS      = DEF_LEVELS,
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS,
    localparam int IN_W  = ((PRIO_W + HANDLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((HANDLE_BITS + PENDING_W + CURTOP_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [MAXLVL_W-1:0] cfg_data,
    input  logic [OPCODE_W-1:0] s_tuser,
    input  logic [IN_W-1:0]     s_tdata,
    output logic [STATUS_W-1:0] m_tuser,
    output logic [OUT_W-1:0]    m_tdata,
    input  mlpq_cmd_t           cmd,
    output mlpq_stat_t          stat
);

    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > PENDING_W) ? CNT_W : PENDING_W;

    logic [MAXLVL_W-1:0]    max_level_reg, max_level_next;
    logic [LEVELS-1:0]      flags_reg, flags_next;
    logic [IDX_W-1:0]       free_head_reg, free_head_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [LVL_W-1:0]       top_reg, top_next;
    logic [LVL_W-1:0]       lv_reg, lv_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [HANDLE_BITS-1:0] popped_reg, popped_next;
    logic [IDX_W-1:0]       pop_entry_reg, pop_entry_next;
    logic                   last_reg, last_next;
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]    m_tuser_reg, m_tuser_next;

    logic [PRIO_W-1:0]      in_prio, lv_clamp;
    logic [HANDLE_BITS-1:0] in_handle;
    logic [LVL_W-1:0]       in_lv, top_dec;
    logic                   fresh;
    logic [IDX_W-1:0]       free_succ;
    logic [EXT_W-1:0]       total_ext;
    logic [PRIO_W-1:0]      top_ext;

    logic                   head_we, tail_we, link_we;
    logic [LVL_W-1:0]       head_waddr, tail_raddr;
    logic [IDX_W-1:0]       head_wdata, link_waddr, link_raddr;
    logic [IDX_W-1:0]       head_q, tail_q, link_q;
    logic [HANDLE_BITS-1:0] pay_q;

    assign in_prio   = s_tdata[PRIO_W-1:0];
    assign in_handle = s_tdata[PRIO_W +: HANDLE_BITS];

    // clamp the requested level to max_level and to the last level
    always_comb begin
        lv_clamp = in_prio;
        if (lv_clamp > PRIO_W'(max_level_reg)) begin
            lv_clamp = PRIO_W'(max_level_reg);
        end
        if (lv_clamp > PRIO_W'(LEVELS - 1)) begin
            lv_clamp = PRIO_W'(LEVELS - 1);
        end
    end
    assign in_lv = lv_clamp[LVL_W-1:0];

    assign top_dec = top_reg - 1'b1;

    // entries at or above the fill mark were never linked: they chain in index order
    assign fresh     = (CNT_W'(free_head_reg) >= fill_reg);
    assign free_succ = fresh ? ((free_head_reg == IDX_W'(CAPACITY - 1)) ? '0
                                                                       : free_head_reg + 1'b1)
                             : link_q;

    assign stat.op        = s_tuser;
    assign stat.pool_full = (total_reg >= CNT_W'(CAPACITY));
    assign stat.top_empty = !flags_reg[top_reg];
    assign stat.pop_last  = last_reg;
    assign stat.fall_done = (top_reg == '0) || flags_reg[top_dec];

    // memory ports
    assign tail_raddr = (s_tuser == OP_PUSH) ? in_lv : top_reg;
    assign link_raddr = cmd.pop_rd ? head_q : free_head_reg;

    assign link_we    = (cmd.push_wr && flags_reg[lv_reg]) || cmd.pop_wr;
    assign link_waddr = cmd.push_wr ? tail_q : pop_entry_reg;

    assign head_we    = (cmd.push_wr && !flags_reg[lv_reg]) || (cmd.pop_wr && !last_reg);
    assign head_waddr = cmd.push_wr ? lv_reg : top_reg;
    assign head_wdata = cmd.push_wr ? free_head_reg : link_q;

    assign tail_we    = cmd.push_wr;

    mlpq_ram #(.WIDTH(IDX_W), .DEPTH(LEVELS)) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (top_reg),
        .rdata (head_q)
    );

    mlpq_ram #(.WIDTH(IDX_W), .DEPTH(LEVELS)) u_tail_ram (
        .aclk  (aclk),
        .we    (tail_we),
        .waddr (lv_reg),
        .wdata (free_head_reg),
        .raddr (tail_raddr),
        .rdata (tail_q)
    );

    mlpq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (free_head_reg),
        .raddr (link_raddr),
        .rdata (link_q)
    );

    mlpq_ram #(.WIDTH(HANDLE_BITS), .DEPTH(CAPACITY)) u_pay_ram (
        .aclk  (aclk),
        .we    (cmd.push_wr),
        .waddr (free_head_reg),
        .wdata (handle_reg),
        .raddr (head_q),
        .rdata (pay_q)
    );

    assign total_ext = EXT_W'(total_reg);
    assign top_ext   = PRIO_W'(top_reg);

    always_comb begin
        max_level_next = max_level_reg;
        flags_next     = flags_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        top_next       = top_reg;
        lv_next        = lv_reg;
        handle_next    = handle_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        pop_entry_next = pop_entry_reg;
        last_next      = last_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (cfg_valid) begin
            max_level_next = cfg_data;
        end

        if (cmd.accept) begin
            lv_next     = in_lv;
            handle_next = in_handle;
            popped_next = '0;
            status_next = ST_OK;
            case (s_tuser)
                OP_PUSH: begin
                    if (stat.pool_full) begin
                        status_next = ST_FULL;
                    end
                end
                OP_POP: begin
                    if (stat.top_empty) begin
                        status_next = ST_EMPTY;
                    end
                end
                OP_CLEAR: begin
                    flags_next     = '0;
                    free_head_next = '0;
                    fill_next      = '0;
                    total_next     = '0;
                    top_next       = '0;
                end
                default: ;
            endcase
        end

        if (cmd.push_wr) begin
            flags_next[lv_reg] = 1'b1;
            free_head_next     = free_succ;
            if (fresh) begin
                fill_next = CNT_W'(free_head_reg) + 1'b1;
            end
            total_next = total_reg + 1'b1;
            if (lv_reg > top_reg) begin
                top_next = lv_reg;
            end
        end

        if (cmd.pop_rd) begin
            pop_entry_next = head_q;
            last_next      = (head_q == tail_q);
        end

        if (cmd.pop_wr) begin
            popped_next = pay_q;
            if (last_reg) begin
                flags_next[top_reg] = 1'b0;
            end
            // return the entry to the front of the free list
            free_head_next = pop_entry_reg;
            total_next     = total_reg - 1'b1;
        end

        if (cmd.fall_step) begin
            top_next = (top_reg == '0) ? '0 : top_dec;
        end

        if (cmd.out_load) begin
            m_tuser_next = status_reg;
            m_tdata_next = '0;
            m_tdata_next[HANDLE_BITS-1:0]                              = popped_reg;
            m_tdata_next[HANDLE_BITS +: PENDING_W]                     = total_ext[PENDING_W-1:0];
            m_tdata_next[HANDLE_BITS + PENDING_W +: CURTOP_W]          = top_ext[CURTOP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_level_reg <= MAX_LEVEL_RESET;
            flags_reg     <= '0;
            free_head_reg <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            top_reg       <= '0;
        end else begin
            max_level_reg <= max_level_next;
            flags_reg     <= flags_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            top_reg       <= top_next;
        end
    end

    always_ff @(posedge aclk) begin
        lv_reg        <= lv_next;
        handle_reg    <= handle_next;
        status_reg    <= status_next;
        popped_reg    <= popped_next;
        pop_entry_reg <= pop_entry_next;
        last_reg      <= last_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the multilevel priority task queue: random and directed operations
// checked against a scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import mlpq_pkg::*;

    localparam int IN_W  = ((PRIO_W + DEF_HANDLE_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((DEF_HANDLE_BITS + PENDING_W + CURTOP_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;   // unused opcode, must be a no-op

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int LIMIT_CYCLES  = 1000000;

    typedef enum logic [1:0] {
        STEP_OP,
        STEP_CFG,
        STEP_DRAIN,
        STEP_HOLD
    } step_kind_t;

    typedef struct packed {
        step_kind_t                 kind;
        logic [OPCODE_W-1:0]        op;
        logic [PRIO_W-1:0]          prio;
        logic [DEF_HANDLE_BITS-1:0] handle;
        logic [MAXLVL_W-1:0]        level;
        logic [7:0]                 gap;
    } plan_step_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic [DEF_HANDLE_BITS-1:0] handle;
        logic [PENDING_W-1:0]       count;
        logic [CURTOP_W-1:0]        top;
    } reply_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [MAXLVL_W-1:0] cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata   = '0;
    logic [OPCODE_W-1:0] s_tuser   = OP_PUSH;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    multilevel_priority_task_queue_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // queue shadow state
    logic [5:0]                 lvl_first   [DEF_LEVELS];
    logic [5:0]                 lvl_last    [DEF_LEVELS];
    logic [DEF_LEVELS-1:0]      lvl_busy;
    logic [5:0]                 next_slot   [DEF_CAPACITY];
    logic [DEF_HANDLE_BITS-1:0] slot_handle [DEF_CAPACITY];
    logic [5:0]                 free_slot;
    logic [PENDING_W-1:0]       queued;
    logic [CURTOP_W-1:0]        top_lvl;
    logic [MAXLVL_W-1:0]        cap_level;

    plan_step_t op_plan[$];
    reply_t     reply_due[$];

    int          mismatches    = 0;
    int unsigned cycles        = 0;
    bit          plan_done     = 1'b0;
    bit          s_took        = 1'b0;
    bit          cfg_took      = 1'b0;
    int unsigned tx_wait       = 0;
    int unsigned settle        = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_seen     = 0;
    int unsigned rx_hold       = 0;
    int unsigned rx_gap        = 0;
    int unsigned rx_phase      = 0;
    bit          rx_calm       = 1'b0;

    function automatic void clear_queues();
        int k;
        for (k = 0; k < DEF_LEVELS; k++) begin
            lvl_first[k] = '0;
            lvl_last[k]  = '0;
        end
        for (k = 0; k < DEF_CAPACITY; k++)
            next_slot[k] = 6'((k + 1) % DEF_CAPACITY);
        lvl_busy  = '0;
        free_slot = '0;
        queued    = '0;
        top_lvl   = '0;
    endfunction

    task automatic model_queue_op(input logic [OPCODE_W-1:0] op, input logic [PRIO_W-1:0] prio,
                                  input logic [DEF_HANDLE_BITS-1:0] handle, output reply_t rep);
        logic [CURTOP_W-1:0] lv;
        logic [5:0]          slot;
        int                  k;
        rep.status = ST_OK;
        rep.handle = '0;
        case (op)
            OP_PUSH: begin
                lv = (prio > cap_level) ? cap_level : prio[CURTOP_W-1:0];
                if (queued >= DEF_CAPACITY) begin
                    rep.status = ST_FULL;
                end else begin
                    slot = free_slot;
                    free_slot = next_slot[slot];
                    slot_handle[slot] = handle;
                    if (lvl_busy[lv]) begin
                        next_slot[lvl_last[lv]] = slot;
                    end else begin
                        lvl_first[lv] = slot;
                        lvl_busy[lv]  = 1'b1;
                    end
                    lvl_last[lv] = slot;
                    queued = queued + 1'b1;
                    if (lv > top_lvl)
                        top_lvl = lv;
                end
            end
            OP_POP: begin
                lv = top_lvl;
                if (!lvl_busy[lv]) begin
                    rep.status = ST_EMPTY;
                end else begin
                    slot = lvl_first[lv];
                    rep.handle = slot_handle[slot];
                    if (lvl_last[lv] == slot) begin
                        // level drained: fall to the highest level still holding tasks
                        lvl_busy[lv] = 1'b0;
                        top_lvl = '0;
                        for (k = 0; k < DEF_LEVELS; k++)
                            if (lvl_busy[k])
                                top_lvl = CURTOP_W'(k);
                    end else begin
                        lvl_first[lv] = next_slot[slot];
                    end
                    next_slot[slot] = free_slot;
                    free_slot = slot;
                    queued = queued - 1'b1;
                end
            end
            OP_CLEAR: clear_queues();
            default: ;
        endcase
        rep.count = queued;
        rep.top   = top_lvl;
    endtask

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        end
    endfunction

    // monitor and scoreboard
    always @(posedge aclk) begin : monitor
        reply_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (reply_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, expected none actual %h/%h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = reply_due.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("popped_handle", want.handle, m_tdata[0 +: DEF_HANDLE_BITS]);
                    check_field("pending_count", want.count,
                                m_tdata[DEF_HANDLE_BITS +: PENDING_W]);
                    check_field("current_top", want.top,
                                m_tdata[DEF_HANDLE_BITS + PENDING_W +: CURTOP_W]);
                end
            end
            if (cfg_valid && cfg_ready)
                cap_level = cfg_data;
            if (s_tvalid && s_tready) begin
                model_queue_op(s_tuser, s_tdata[0 +: PRIO_W],
                               s_tdata[PRIO_W +: DEF_HANDLE_BITS], want);
                reply_due.push_back(want);
            end
            s_took   <= s_tvalid && s_tready;
            cfg_took <= cfg_valid && cfg_ready;
        end
    end

    // driver: operation and configuration channels
    always @(negedge aclk) begin : driver
        logic       nx_valid;
        logic       nx_cfg;
        plan_step_t step;
        nx_valid = s_tvalid;
        nx_cfg   = cfg_valid;
        if (aresetn) begin
            if (s_took)
                nx_valid = 1'b0;
            if (cfg_took)
                nx_cfg = 1'b0;
            if (!nx_valid && !nx_cfg) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (settle > 0) begin
                    // hold until every result is back, then let the block settle
                    if (reply_due.size() == 0)
                        settle--;
                end else if (op_plan.size() != 0) begin
                    step = op_plan.pop_front();
                    case (step.kind)
                        STEP_OP: begin
                            nx_valid = 1'b1;
                            s_tuser <= step.op;
                            s_tdata <= IN_W'({step.handle, step.prio});
                            tx_wait  = step.gap;
                        end
                        STEP_CFG: begin
                            nx_cfg = 1'b1;
                            cfg_data <= step.level;
                        end
                        STEP_DRAIN: settle = SETTLE_CYCLES;
                        STEP_HOLD:  hold_requests <= hold_requests + 1;
                        default: ;
                    endcase
                end else begin
                    plan_done = 1'b1;
                end
            end
            s_tvalid  <= nx_valid;
            cfg_valid <= nx_cfg;
        end
    end

    // result receiver: random backpressure, calm stretches and one long hold-off
    always @(negedge aclk) begin : receiver
        logic        rdy;
        int unsigned r;
        rdy = 1'b1;
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            rx_hold   = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            rdy = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            rdy = 1'b0;
        end else begin
            if (rx_phase == 0) begin
                rx_calm  = ($urandom_range(0, 3) == 0);
                rx_phase = $urandom_range(50, 300);
            end else begin
                rx_phase--;
            end
            if (!rx_calm) begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    rx_gap = $urandom_range(1, 3);
                else if (r < 29)
                    rx_gap = $urandom_range(8, 40);
            end
        end
        m_tready <= rdy;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_gap(input bit calm);
        int unsigned r;
        if (calm)
            return 8'd0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'd0;
        if (r < 92)
            return 8'($urandom_range(1, 3));
        return 8'($urandom_range(8, 40));
    endfunction

    task automatic add_op(input logic [OPCODE_W-1:0] op, input logic [PRIO_W-1:0] prio,
                          input logic [DEF_HANDLE_BITS-1:0] handle, input bit calm);
        plan_step_t s;
        s        = '0;
        s.kind   = STEP_OP;
        s.op     = op;
        s.prio   = prio;
        s.handle = handle;
        s.gap    = pick_gap(calm);
        op_plan.push_back(s);
    endtask

    task automatic add_marker(input step_kind_t kind, input logic [MAXLVL_W-1:0] level);
        plan_step_t s;
        s       = '0;
        s.kind  = kind;
        s.level = level;
        op_plan.push_back(s);
    endtask

    task automatic add_mix(input int count, input int push_pct, input int pop_pct,
                           input bit wide, input bit calm);
        int                  k;
        int unsigned         r;
        logic [OPCODE_W-1:0] op;
        logic [PRIO_W-1:0]   prio;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                op = OP_PUSH;
            else if (r < push_pct + pop_pct)
                op = OP_POP;
            else if (r[0])
                op = OP_CLEAR;
            else
                op = OP_NOP;
            if (wide || $urandom_range(0, 7) == 0)
                prio = PRIO_W'($urandom_range(0, 255));
            else
                prio = PRIO_W'($urandom_range(0, 7));
            add_op(op, prio, DEF_HANDLE_BITS'($urandom), calm);
        end
    endtask

    initial begin : main
        logic [MAXLVL_W-1:0] phase_level [6];
        int                  p;
        cap_level = MAX_LEVEL_RESET;
        clear_queues();
        for (p = 0; p < DEF_CAPACITY; p++)
            slot_handle[p] = '0;

        // directed: empty pop, no-op, clamping, FIFO order per level, top walk, clear
        add_op(OP_POP,   8'd0,   16'h0000, 1'b0);
        add_op(OP_NOP,   8'hFF,  16'hFFFF, 1'b0);
        add_op(OP_PUSH,  8'd0,   16'h0000, 1'b0);
        add_op(OP_PUSH,  8'd255, 16'hFFFF, 1'b0);
        add_op(OP_PUSH,  8'd7,   16'h1234, 1'b0);
        add_op(OP_PUSH,  8'd3,   16'hA5A5, 1'b0);
        add_op(OP_PUSH,  8'd8,   16'h5A5A, 1'b0);
        add_op(OP_PUSH,  8'd1,   16'h0001, 1'b0);
        for (p = 0; p < 7; p++)
            add_op(OP_POP, 8'd0, 16'h0000, 1'b0);
        add_op(OP_PUSH,  8'd2,   16'h00FF, 1'b0);
        add_op(OP_PUSH,  8'd6,   16'hFF00, 1'b0);
        add_op(OP_CLEAR, 8'd0,   16'h0000, 1'b0);
        add_op(OP_POP,   8'd0,   16'h0000, 1'b0);
        add_op(OP_PUSH,  8'd4,   16'hC3C3, 1'b0);
        add_op(OP_NOP,   8'd0,   16'h0000, 1'b0);
        add_op(OP_POP,   8'd0,   16'h0000, 1'b0);

        phase_level[0] = 3'd0;
        phase_level[1] = 3'd7;
        phase_level[2] = 3'd3;
        phase_level[3] = 3'd1;
        phase_level[4] = 3'd6;
        phase_level[5] = MAXLVL_W'($urandom_range(0, 7));
        for (p = 0; p < 6; p++) begin
            add_marker(STEP_DRAIN, '0);
            add_marker(STEP_CFG, phase_level[p]);
            add_mix(80, 52, 44, 1'b0, 1'b0);
            // fill past the pool size; in one phase the receiver stalls meanwhile
            if (p == 1)
                add_marker(STEP_HOLD, '0);
            add_mix(85, 97, 3, 1'b0, p[0]);
            add_mix(80, 20, 78, 1'b0, 1'b0);
            add_mix(50, 50, 46, 1'b1, 1'b0);
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (!plan_done)
            @(posedge aclk);
        while (reply_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mlpq_pkg.sv
hw/rtl/mlpq_ram.sv
hw/rtl/mlpq_ctrl.sv
hw/rtl/mlpq_datapath.sv
hw/rtl/multilevel_priority_task_queue_top.sv
tb/sv/tb_top.sv
